>>> hdl/obea_pkg.sv
`default_nettype none

package obea_pkg;

	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = 3;
	localparam int REG_W     = 16;
	localparam int SAMPLE_W  = 16;
	localparam int LP_W      = 24;
	localparam int LEVEL_W   = 16;
	localparam int MAX_BANDS = 8;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_COEF0   = 3'd0,
		REG_COEF1   = 3'd1,
		REG_COEF2   = 3'd2,
		REG_COEF3   = 3'd3,
		REG_COEF4   = 3'd4,
		REG_COEF5   = 3'd5,
		REG_COEF6   = 3'd6,
		REG_RELEASE = 3'd7
	} obea_reg_t;

	localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
		16'd937, 16'd2110, 16'd4552, 16'd9526,
		16'd18905, 16'd33636, 16'd50006, 16'd65527
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_a;
		logic signed [SAMPLE_W-1:0] sample_b;
	} obea_in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_0;
		logic [LEVEL_W-1:0] level_1;
		logic [LEVEL_W-1:0] level_2;
		logic [LEVEL_W-1:0] level_3;
		logic [LEVEL_W-1:0] level_4;
		logic [LEVEL_W-1:0] level_5;
		logic [LEVEL_W-1:0] level_6;
		logic [LEVEL_W-1:0] level_7;
	} obea_out_t;

endpackage

`default_nettype wire

>>> hdl/obea_lane.sv
`default_nettype none

module obea_lane
	import obea_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic signed [LP_W-1:0] x,
	input  wire logic [REG_W-1:0]       coef,
	output logic signed [LP_W-1:0]      lp
);

	localparam int DIFF_W = LP_W + 1;
	localparam int PROD_W = DIFF_W + REG_W + 1;

	logic signed [LP_W-1:0]   lp_q;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] step;

	// one-pole update, rounded to nearest with ties upward
	assign diff = {x[LP_W-1], x} - {lp_q[LP_W-1], lp_q};
	assign prod = $signed({1'b0, coef}) * diff;
	assign step = (prod + PROD_W'(32768)) >>> REG_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
		end else if (en) begin
			lp_q <= lp_q + step[LP_W-1:0];
		end
	end

	assign lp = lp_q;

endmodule

`default_nettype wire

>>> hdl/obea_merge.sv
`default_nettype none

module obea_merge
	import obea_pkg::*;
#(
	parameter int BANDS = 8
) (
	input  wire logic                         clk,
	input  wire logic                         en,
	input  wire logic [BANDS-2:0][LP_W-1:0]   lp,
	input  wire logic signed [LP_W-1:0]       x,
	output logic [BANDS-1:0][LEVEL_W-1:0]     mag_s3
);

	localparam int D_W = LP_W + 1;

	function automatic logic [LEVEL_W-1:0] to_level(input logic [D_W-1:0] d);
		logic [D_W-1:0] m;
		logic [D_W:0]   r;
		m = d[D_W-1] ? (~d + D_W'(1)) : d;
		r = {1'b0, m} + (D_W+1)'(128);
		if (|r[D_W:LEVEL_W+8]) begin
			to_level = '1;
		end else begin
			to_level = r[LEVEL_W+7:8];
		end
	endfunction

	logic [BANDS-1:0][D_W-1:0] diff;

	for (genvar k = 0; k < BANDS; k++) begin : g_band
		if (k == 0) begin : g_low
			assign diff[k] = {lp[0][LP_W-1], lp[0]};
		end else if (k == BANDS - 1) begin : g_top
			assign diff[k] = {x[LP_W-1], x} - {lp[k-1][LP_W-1], lp[k-1]};
		end else begin : g_mid
			assign diff[k] = {lp[k][LP_W-1], lp[k]} - {lp[k-1][LP_W-1], lp[k-1]};
		end
	end

	// rounded band magnitudes, saturated at full scale
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < BANDS; k++) begin
				mag_s3[k] <= to_level(diff[k]);
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/obea_env.sv
`default_nettype none

module obea_env
	import obea_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [LEVEL_W-1:0] mag,
	input  wire logic [REG_W-1:0]   release_factor,
	output logic [LEVEL_W-1:0]      env
);

	logic [LEVEL_W-1:0]       env_q;
	logic [LEVEL_W+REG_W-1:0] prod;
	logic [LEVEL_W-1:0]       decayed;

	assign prod    = env_q * release_factor;
	assign decayed = prod[LEVEL_W+REG_W-1:REG_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= '0;
		end else if (en) begin
			env_q <= (mag > decayed) ? mag : decayed;
		end
	end

	assign env = env_q;

endmodule

`default_nettype wire

>>> hdl/octave_band_envelope_analyser.sv
// channel | direction | handshake          | payload
// in      | into      | in_valid/in_stall  | in_data: sample_a, sample_b
// out     | out of    | out_valid/out_stall| out_data: level_0 .. level_7
// cfg     | into      | wr_en              | wr_index, wr_data
//
// one frame per clock sustained while out_stall is low; a frame reaches the output through
// four registered stages (mono, lowpass lanes, band magnitudes, envelopes)
// the rate is set by the lowpass and envelope recurrences, each one multiply
// and update closed combinationally around its own state register
// reset zeroes all lowpass and envelope state and loads the default registers
// out_stall holds full stages back from the output end, and in_stall rises only once all four are
`default_nettype none

module octave_band_envelope_analyser
	import obea_pkg::*;
#(
	parameter int CHANNELS = 2,
	parameter int BANDS    = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire obea_in_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output obea_out_t                 out_data,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [REG_W-1:0]     wr_data
);

	localparam int NUM_LP = BANDS - 1;

	logic [REG_W-1:0] reg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				reg_q[i] <= REG_RESET[i];
			end
		end else if (wr_en) begin
			reg_q[wr_index] <= wr_data;
		end
	end

	// stage control
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic take, mv12, mv23, mv34;

	assign rdy4 = !v_s4 || !out_stall;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign take = in_valid && rdy1;
	assign mv12 = v_s1 && rdy2;
	assign mv23 = v_s2 && rdy3;
	assign mv34 = v_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (take) begin
				v_s1 <= 1'b1;
			end else if (mv12) begin
				v_s1 <= 1'b0;
			end
			if (mv12) begin
				v_s2 <= 1'b1;
			end else if (mv23) begin
				v_s2 <= 1'b0;
			end
			if (mv23) begin
				v_s3 <= 1'b1;
			end else if (mv34) begin
				v_s3 <= 1'b0;
			end
			if (mv34) begin
				v_s4 <= 1'b1;
			end else if (!out_stall) begin
				v_s4 <= 1'b0;
			end
		end
	end

	assign in_stall  = !rdy1;
	assign out_valid = v_s4;

	// mono mix into Q1.23
	logic signed [LP_W-1:0] mono;
	logic signed [LP_W-1:0] x_s1;
	logic signed [LP_W-1:0] x_s2;

	if (CHANNELS == 2) begin : g_stereo
		logic signed [SAMPLE_W:0] pair;
		assign pair = {in_data.sample_a[SAMPLE_W-1], in_data.sample_a}
			+ {in_data.sample_b[SAMPLE_W-1], in_data.sample_b};
		assign mono = {pair, {(LP_W-SAMPLE_W-1){1'b0}}};
	end else begin : g_mono
		assign mono = {in_data.sample_a, {(LP_W-SAMPLE_W){1'b0}}};
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1 <= mono;
		end
		if (mv12) begin
			x_s2 <= x_s1;
		end
	end

	// lowpass lanes, state advances on the transfer into stage two
	logic [NUM_LP-1:0][LP_W-1:0] lp;

	for (genvar k = 0; k < NUM_LP; k++) begin : g_lane
		logic signed [LP_W-1:0] lp_k;
		obea_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (mv12),
			.x      (x_s1),
			.coef   (reg_q[k]),
			.lp     (lp_k)
		);
		assign lp[k] = lp_k;
	end

	logic [BANDS-1:0][LEVEL_W-1:0] mag_s3;

	obea_merge #(
		.BANDS (BANDS)
	) u_merge (
		.clk    (clk),
		.en     (mv23),
		.lp     (lp),
		.x      (x_s2),
		.mag_s3 (mag_s3)
	);

	logic [BANDS-1:0][LEVEL_W-1:0]     env;
	logic [MAX_BANDS-1:0][LEVEL_W-1:0] lev;

	for (genvar k = 0; k < MAX_BANDS; k++) begin : g_env
		if (k < BANDS) begin : g_used
			obea_env u_env (
				.clk            (clk),
				.arst_n         (arst_n),
				.en             (mv34),
				.mag            (mag_s3[k]),
				.release_factor (reg_q[REG_RELEASE]),
				.env            (env[k])
			);
			assign lev[k] = env[k];
		end else begin : g_unused
			assign lev[k] = '0;
		end
	end

	assign out_data.level_0 = lev[0];
	assign out_data.level_1 = lev[1];
	assign out_data.level_2 = lev[2];
	assign out_data.level_3 = lev[3];
	assign out_data.level_4 = lev[4];
	assign out_data.level_5 = lev[5];
	assign out_data.level_6 = lev[6];
	assign out_data.level_7 = lev[7];

	// lowpass state moves only with a frame entering the lanes
	a_lp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!mv12 |=> $stable(lp))
		else $error("lowpass state changed without a transfer");

	// envelopes move only with a frame entering the last stage
	a_env_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!mv34 |=> $stable(env))
		else $error("envelope changed without a transfer");

	// an updated top-band envelope never falls below the band magnitude that fed it
	a_env_peak: assert property (@(posedge clk) disable iff (!arst_n)
		mv34 |=> env[BANDS-1] >= $past(mag_s3[BANDS-1]))
		else $error("envelope below its band magnitude");

	// a frame held in the lane stage keeps its mono sample
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy3 |=> v_s2 && $stable(x_s2))
		else $error("stage two lost or changed its frame");

endmodule

`default_nettype wire
